/* src/sfc_pkg.sv */
// Shared types, constants and helpers for the six-axis force calibration block.
package sfc_pkg;

	localparam int CHANNELS = 6;
	localparam int COEFS = CHANNELS * CHANNELS;
	localparam int CIW = 6;
	localparam int FORCE_W = 32;
	localparam int SATW = 80;

	localparam int DEF_WINDOW = 20;
	localparam int DEF_ZERO_COUNT = 20;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_COEF_FRAC_BITS = 16;

	localparam logic [2:0] OP_SAMPLE = 3'd0;
	localparam logic [2:0] OP_COEF   = 3'd1;
	localparam logic [2:0] OP_START  = 3'd2;
	localparam logic [2:0] OP_CANCEL = 3'd3;
	localparam logic [2:0] OP_ACK    = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SAMPLE,
		CMD_COEF,
		CMD_START,
		CMD_CANCEL,
		CMD_ACK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [CIW-1:0] coef_index;
		logic [FORCE_W-1:0] coef_value;
	} cmd_t;

	typedef struct packed {
		logic [CHANNELS-1:0][FORCE_W-1:0] force_v;
		logic zero_active;
		logic zero_done;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RING_RD,
		ST_RING_WR,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_BYPASS,
		ST_MAC,
		ST_MAC_DRAIN,
		ST_ZACC,
		ST_ZDIV_GO,
		ST_ZDIV_WAIT,
		ST_EMIT
	} state_t;

	localparam logic signed [SATW-1:0] MAX32 = SATW'(64'sh7FFFFFFF);
	localparam logic signed [SATW-1:0] MIN32 = -MAX32 - SATW'(1);

	function automatic logic signed [FORCE_W-1:0] sat32(input logic signed [SATW-1:0] v);
		logic signed [FORCE_W-1:0] r;
		if (v > MAX32)
			r = MAX32[FORCE_W-1:0];
		else if (v < MIN32)
			r = MIN32[FORCE_W-1:0];
		else
			r = v[FORCE_W-1:0];
		return r;
	endfunction

endpackage

/* src/sfc_ram.sv */
// Generic single write port RAM with registered read.
module sfc_ram #(
	parameter int W = 32,
	parameter int D = 36
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* src/sfc_fifo.sv */
// Small register queue with first-word-through output.
module sfc_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + NW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

/* src/sfc_front.sv */
// Front end: takes input words, classifies the operation and queues commands.
module sfc_front import sfc_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic [2:0]                              operation,
	input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    samples_in,
	input  logic [CIW-1:0]                          coef_index,
	input  logic [FORCE_W-1:0]                      coef_value,
	output logic                                    cmd_valid,
	output cmd_t                                    cmd,
	output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    samples_out,
	input  logic                                    cmd_pop
);

	localparam int SW = CHANNELS * SAMPLE_BITS;
	localparam int QW = $bits(cmd_t) + SW;

	cmd_t        cls;
	logic        q_empty;
	logic [QW-1:0] q_out;

	always_comb begin
		cls.coef_index = coef_index;
		cls.coef_value = coef_value;
		unique case (operation)
			OP_SAMPLE: cls.kind = CMD_SAMPLE;
			OP_COEF:   cls.kind = (coef_index < CIW'(COEFS)) ? CMD_COEF : CMD_NONE;
			OP_START:  cls.kind = CMD_START;
			OP_CANCEL: cls.kind = CMD_CANCEL;
			OP_ACK:    cls.kind = CMD_ACK;
			default:   cls.kind = CMD_NONE;
		endcase
	end

	sfc_fifo #(.W(QW), .DEPTH(2)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && (cls.kind != CMD_NONE)),
		.wdata ({cls, samples_in}),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (q_out),
		.empty (q_empty)
	);

	assign cmd_valid   = !q_empty;
	assign cmd         = cmd_t'(q_out[QW-1:SW]);
	assign samples_out = q_out[SW-1:0];

endmodule

/* src/sfc_div.sv */
// Iterative rounding divider: round to nearest, ties away from zero.
module sfc_div #(
	parameter int DW = 37,
	parameter int CW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic [CW-1:0]        divisor,
	output logic                 done,
	output logic signed [DW-1:0] quot
);

	localparam int MW = DW + 1;
	localparam int KW = $clog2(MW + 1);

	logic [MW-1:0] num_q;
	logic [CW-1:0] rem_q, dsr_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q, neg_q, done_q;
	logic [MW-1:0] mag;
	logic [CW:0]   rem_try;
	logic          fits;

	always_comb begin
		mag = dividend[DW-1] ? -MW'(dividend) : MW'(dividend);
		mag = mag + MW'(divisor >> 1);
		rem_try = {rem_q, num_q[MW-1]};
		fits = (rem_try >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DW-1];
		end else if (busy_q) begin
			rem_q <= fits ? CW'(rem_try - {1'b0, dsr_q}) : rem_try[CW-1:0];
			num_q <= {num_q[MW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -num_q[DW-1:0] : num_q[DW-1:0];

endmodule

/* src/sfc_back.sv */
// Back end: ring update, averaging, matrix, zero offsets and result assembly.
module sfc_back import sfc_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW,
	parameter int ZERO_COUNT = DEF_ZERO_COUNT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 use_matrix,
	input  logic                                 cmd_valid,
	input  cmd_t                                 cmd,
	input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples,
	output logic                                 cmd_pop,
	input  logic                                 res_full,
	output logic                                 res_push,
	output res_t                                 res
);

	localparam int FILLW = $clog2(WINDOW + 1);
	localparam int PTRW  = $clog2(WINDOW);
	localparam int RD    = CHANNELS * WINDOW;
	localparam int RAW   = $clog2(RD);
	localparam int SUMW  = SAMPLE_BITS + FILLW;
	localparam int ZCW   = $clog2(ZERO_COUNT + 1);
	localparam int ZSW   = FORCE_W + ZCW;
	localparam int DW    = (SUMW > ZSW) ? SUMW : ZSW;
	localparam int CW    = (FILLW > ZCW) ? FILLW : ZCW;
	localparam int UW    = SAMPLE_BITS + 1;
	localparam int PW    = FORCE_W + UW;
	localparam int ACW   = PW + 3;
	localparam logic signed [ACW:0] HALF = (ACW+1)'(1) <<< (COEF_FRAC_BITS - 1);

	state_t state_q, state_d;

	logic [2:0]        ch_q, row_q, col_q;
	logic [PTRW-1:0]   pos_q;
	logic [FILLW-1:0]  fill_q;
	logic [ZCW-1:0]    zcnt_q;
	logic              active_q, done_q;
	logic signed [SUMW-1:0]    sum_q  [CHANNELS];
	logic signed [ZSW-1:0]     zsum_q [CHANNELS];
	logic signed [FORCE_W-1:0] off_q  [CHANNELS];
	logic signed [UW-1:0]      u_q    [CHANNELS];
	logic signed [FORCE_W-1:0] f_q    [CHANNELS];
	logic [COEFS-1:0]  cvld_q;

	logic              v_s1, v_s2, v_s3, cvld_s1;
	logic [2:0]        row_s1, col_s1, row_s2, col_s2, row_s3;
	logic signed [PW-1:0]  prod_s2;
	logic signed [ACW-1:0] acc_q, acc_next, sum_s3;

	logic              ring_we, coef_we, mac_issue, div_start, div_done;
	logic [RAW-1:0]    ring_addr;
	logic [SAMPLE_BITS-1:0] ring_rdata;
	logic [FORCE_W-1:0] coef_rdata;
	logic [CIW-1:0]    coef_raddr;
	logic signed [DW-1:0] div_num, div_q;
	logic [CW-1:0]     div_dsr;
	logic              ring_full, zero_last;
	logic signed [SAMPLE_BITS-1:0] x_cur;

	assign ring_full  = (fill_q == FILLW'(WINDOW));
	assign zero_last  = ((ZCW+1)'(zcnt_q) + (ZCW+1)'(1) >= (ZCW+1)'(ZERO_COUNT));
	assign ring_addr  = RAW'(RAW'(ch_q) * RAW'(WINDOW) + RAW'(pos_q));
	assign coef_raddr = CIW'(CIW'(row_q) * CIW'(CHANNELS) + CIW'(col_q));
	assign x_cur      = signed'(samples[ch_q]);

	sfc_ram #(.W(SAMPLE_BITS), .D(RD)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_addr), .wdata(samples[ch_q]),
		.raddr(ring_addr), .rdata(ring_rdata)
	);

	sfc_ram #(.W(FORCE_W), .D(COEFS)) u_coef (
		.clk(clk), .we(coef_we), .waddr(cmd.coef_index), .wdata(cmd.coef_value),
		.raddr(coef_raddr), .rdata(coef_rdata)
	);

	always_comb begin
		div_num = (state_q == ST_ZDIV_GO) ? DW'(zsum_q[ch_q]) : DW'(sum_q[ch_q]);
		div_dsr = (state_q == ST_ZDIV_GO) ? CW'(ZERO_COUNT) : CW'(fill_q);
	end

	sfc_div #(.DW(DW), .CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_dsr), .done(div_done), .quot(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		coef_we   = 1'b0;
		ring_we   = 1'b0;
		mac_issue = 1'b0;
		div_start = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					// a sample word stays queued until its channels are in the ring
					cmd_pop = (cmd.kind != CMD_SAMPLE);
					coef_we = (cmd.kind == CMD_COEF);
					if (cmd.kind == CMD_SAMPLE)
						state_d = ST_RING_RD;
				end
			end
			ST_RING_RD: state_d = ST_RING_WR;
			ST_RING_WR: begin
				ring_we = 1'b1;
				cmd_pop = (ch_q == 3'(CHANNELS - 1));
				state_d = (ch_q == 3'(CHANNELS - 1)) ? ST_AVG_GO : ST_RING_RD;
			end
			ST_AVG_GO: begin
				div_start = 1'b1;
				state_d   = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (div_done) begin
					if (ch_q != 3'(CHANNELS - 1))
						state_d = ST_AVG_GO;
					else
						state_d = use_matrix ? ST_MAC : ST_BYPASS;
				end
			end
			ST_BYPASS: state_d = ST_ZACC;
			ST_MAC: begin
				mac_issue = 1'b1;
				if (row_q == 3'(CHANNELS - 1) && col_q == 3'(CHANNELS - 1))
					state_d = ST_MAC_DRAIN;
			end
			ST_MAC_DRAIN: begin
				if (v_s3 && row_s3 == 3'(CHANNELS - 1))
					state_d = ST_ZACC;
			end
			ST_ZACC: state_d = (ring_full && active_q && zero_last) ? ST_ZDIV_GO : ST_EMIT;
			ST_ZDIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_ZDIV_WAIT;
			end
			ST_ZDIV_WAIT: begin
				if (div_done)
					state_d = (ch_q == 3'(CHANNELS - 1)) ? ST_EMIT : ST_ZDIV_GO;
			end
			ST_EMIT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and reset-cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q     <= '0;
			row_q    <= '0;
			col_q    <= '0;
			pos_q    <= '0;
			fill_q   <= '0;
			zcnt_q   <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cvld_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				zsum_q[i] <= '0;
				off_q[i]  <= '0;
			end
		end else begin
			v_s1 <= mac_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (col_s2 == 3'(CHANNELS - 1));
			if (coef_we)
				cvld_q[cmd.coef_index] <= 1'b1;
			if (state_q == ST_IDLE && cmd_valid) begin
				ch_q  <= '0;
				row_q <= '0;
				col_q <= '0;
				unique case (cmd.kind)
					CMD_START: begin
						zcnt_q   <= '0;
						active_q <= 1'b1;
						done_q   <= 1'b0;
						for (int i = 0; i < CHANNELS; i++)
							zsum_q[i] <= '0;
					end
					CMD_CANCEL: begin
						zcnt_q   <= '0;
						active_q <= 1'b0;
						done_q   <= 1'b0;
						for (int i = 0; i < CHANNELS; i++) begin
							zsum_q[i] <= '0;
							off_q[i]  <= '0;
						end
					end
					CMD_ACK: done_q <= 1'b0;
					CMD_NONE, CMD_SAMPLE, CMD_COEF: ;
					default: ;
				endcase
			end
			if (ring_we) begin
				sum_q[ch_q] <= sum_q[ch_q] + SUMW'(x_cur)
					- (ring_full ? SUMW'(signed'(ring_rdata)) : SUMW'(0));
				if (ch_q == 3'(CHANNELS - 1)) begin
					ch_q  <= '0;
					pos_q <= (pos_q == PTRW'(WINDOW - 1)) ? '0 : pos_q + PTRW'(1);
					if (!ring_full)
						fill_q <= fill_q + FILLW'(1);
				end else
					ch_q <= ch_q + 3'(1);
			end
			if (state_q == ST_AVG_WAIT && div_done && ch_q != 3'(CHANNELS - 1))
				ch_q <= ch_q + 3'(1);
			if (mac_issue) begin
				if (col_q == 3'(CHANNELS - 1)) begin
					col_q <= '0;
					row_q <= row_q + 3'(1);
				end else
					col_q <= col_q + 3'(1);
			end
			if (state_q == ST_ZACC) begin
				ch_q <= '0;
				if (ring_full && active_q) begin
					zcnt_q <= zcnt_q + ZCW'(1);
					for (int i = 0; i < CHANNELS; i++)
						zsum_q[i] <= zsum_q[i] + ZSW'(f_q[i]);
				end
			end
			if (state_q == ST_ZDIV_WAIT && div_done) begin
				off_q[ch_q] <= sat32(SATW'(div_q));
				if (ch_q == 3'(CHANNELS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else
					ch_q <= ch_q + 3'(1);
			end
		end
	end

	always_comb begin
		acc_next = (col_s2 == '0) ? ACW'(prod_s2) : acc_q + ACW'(prod_s2);
	end

	// datapath
	always_ff @(posedge clk) begin
		row_s1  <= row_q;
		col_s1  <= col_q;
		cvld_s1 <= cvld_q[coef_raddr];
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		prod_s2 <= cvld_s1 ? PW'(signed'(coef_rdata)) * PW'(u_q[col_s1]) : '0;
		if (v_s2) begin
			acc_q  <= acc_next;
			sum_s3 <= acc_next;
			row_s3 <= row_s2;
		end
		if (v_s3)
			f_q[row_s3] <= sat32(SATW'(((ACW+1)'(sum_s3) + HALF) >>> COEF_FRAC_BITS));
		if (state_q == ST_AVG_WAIT && div_done)
			u_q[ch_q] <= div_q[UW-1:0];
		if (state_q == ST_BYPASS)
			for (int i = 0; i < CHANNELS; i++)
				f_q[i] <= FORCE_W'(u_q[i]);
	end

	always_comb begin
		for (int i = 0; i < CHANNELS; i++)
			res.force_v[i] = sat32(SATW'(f_q[i]) - SATW'(off_q[i]));
		res.zero_active = active_q;
		res.zero_done   = done_q;
	end

endmodule

/* src/six_axis_force_calibration.sv */
// Six-axis force calibration: top level.
//
// Input channel (push/full): one word per cycle while full is low. Operation
// sample produces one result word; load coefficient, start zero, cancel zero
// and acknowledge produce none, as do unknown codes and coefficient indexes
// past 35 (dropped at the front end).
// Result channel (empty/pop): forces force_0..force_5 in Q32.0 with the zero
// collection flags as they stand after the sample.
// A two-entry command queue decouples the front end from the sequencer, and a
// two-entry result queue lets the sequencer finish the next word while a
// result waits to be popped; full is high whenever the command queue is full.
// Sample processing: each channel is read from and then written to the ring
// RAM, then six serial divisions form the averages, then the matrix (36
// coefficient reads through a 3-stage MAC) or its bypass, and on the sample
// that ends zero collection six more divisions; the divider is shared by both.
// Reset clears the queues, sums, offsets, coefficient valid bits and flags;
// the sample ring is not cleared and is read only once filled. The user
// writes use_matrix via cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
module six_axis_force_calibration import sfc_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW,
	parameter int ZERO_COUNT = DEF_ZERO_COUNT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [2:0]                    operation,
	input  logic signed [SAMPLE_BITS-1:0] sample_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_3,
	input  logic signed [SAMPLE_BITS-1:0] sample_4,
	input  logic signed [SAMPLE_BITS-1:0] sample_5,
	input  logic [5:0]                    coef_index,
	input  logic signed [31:0]            coef_value,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            force_0,
	output logic signed [31:0]            force_1,
	output logic signed [31:0]            force_2,
	output logic signed [31:0]            force_3,
	output logic signed [31:0]            force_4,
	output logic signed [31:0]            force_5,
	output logic                          zero_active,
	output logic                          zero_done
);

	logic use_matrix_q;
	logic cmd_valid, cmd_pop, res_full, res_push;
	cmd_t cmd;
	res_t res_in, res_out;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples_in, samples_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			use_matrix_q <= 1'b0;
		else if (cfg_we)
			use_matrix_q <= cfg_wdata;
	end

	assign samples_in = {sample_5, sample_4, sample_3, sample_2, sample_1, sample_0};

	sfc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .samples_in(samples_in),
		.coef_index(coef_index), .coef_value(coef_value),
		.cmd_valid(cmd_valid), .cmd(cmd), .samples_out(samples_q), .cmd_pop(cmd_pop)
	);

	sfc_back #(
		.WINDOW(WINDOW), .ZERO_COUNT(ZERO_COUNT),
		.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .use_matrix(use_matrix_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .samples(samples_q), .cmd_pop(cmd_pop),
		.res_full(res_full), .res_push(res_push), .res(res_in)
	);

	sfc_fifo #(.W($bits(res_t)), .DEPTH(2)) u_resq (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(res_in),
		.full(res_full), .pop(pop), .rdata(res_out), .empty(empty)
	);

	assign force_0     = res_out.force_v[0];
	assign force_1     = res_out.force_v[1];
	assign force_2     = res_out.force_v[2];
	assign force_3     = res_out.force_v[3];
	assign force_4     = res_out.force_v[4];
	assign force_5     = res_out.force_v[5];
	assign zero_active = res_out.zero_active;
	assign zero_done   = res_out.zero_done;

endmodule

/* src/sfc_checker.sv */
// Port-level checks for the six-axis force calibration block, with bind.
module sfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] force_0,
	input logic        zero_active,
	input logic        zero_done
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result word present during reset");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(zero_active && zero_done))
		else $error("zero active and done together");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(force_0) && $stable(zero_done))
		else $error("stalled result word changed");

endmodule

bind six_axis_force_calibration sfc_checker u_sfc_checker (.*);
